>>> rtl/dot_matrix_sketch_pad_defines.svh
// Assertion macros for the sketch pad.
// DMSP_ASSERT_SAME: the consequent must hold in the same cycle.
// DMSP_ASSERT_NEXT: the consequent must hold one cycle later.
`ifndef DOT_MATRIX_SKETCH_PAD_DEFINES_SVH
`define DOT_MATRIX_SKETCH_PAD_DEFINES_SVH

`ifndef SYNTHESIS
`define DMSP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dmsp: same-cycle check failed");
`define DMSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dmsp: next-cycle check failed");
`else
`define DMSP_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define DMSP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> rtl/dmsp_pkg.sv
`default_nettype none

package dmsp_pkg;

   // fixed field widths
   localparam int COLS      = 7;
   localparam int COL_W     = 3;
   localparam int ROW_IDX_W = 4;
   localparam int COUNT_W   = 14;
   localparam int MODE_W    = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(9999);

   // key codes
   typedef enum logic [MODE_W-1:0] {
      KEY_NONE   = 4'd0,
      KEY_RESET  = 4'd1,
      KEY_UP     = 4'd2,
      KEY_TOGGLE = 4'd3,
      KEY_LEFT   = 4'd4,
      KEY_SET    = 4'd5,
      KEY_RIGHT  = 4'd6,
      KEY_CLEAR  = 4'd7,
      KEY_DOWN   = 4'd8,
      KEY_INVERT = 4'd9
   } key_type;

   // what the row sweep does to each stored row
   typedef enum logic [1:0] {
      OP_KEEP,
      OP_CLEAR,
      OP_INVERT,
      OP_SET
   } op_type;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              key_valid;
      logic              blink_phase;
   } req_type;

   typedef struct packed {
      logic [ROW_IDX_W-1:0] row_index;
      logic [COLS-1:0]      row_bits;
      logic [COUNT_W-1:0]   press_count;
      logic                 last_row;
   } rsp_type;

   // per-item context handed from the key decoder to the row sweep
   typedef struct packed {
      op_type               op;
      logic [ROW_IDX_W-1:0] cur_row;
      logic [COL_W-1:0]     cur_col;
      logic                 visible;
      logic                 blink;
      logic [COUNT_W-1:0]   count;
   } item_type;

   // one-hot dot for a column, column 0 at the MSB
   function automatic logic [COLS-1:0] col_mask(input logic [COL_W-1:0] col);
      logic [COLS-1:0]  mask;
      logic [COL_W-1:0] pos;
      mask      = '0;
      pos       = COL_W'(COLS - 1) - col;
      mask[pos] = 1'b1;
      return mask;
   endfunction

endpackage

`default_nettype wire

>>> rtl/dmsp_ram.sv
`default_nettype none

// simple dual-port RAM, registered read
module dmsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/dmsp_cmd.sv
`default_nettype none

// key decoder: cursor, visibility, press counter and the pending board op
module dmsp_cmd
   import dmsp_pkg::*;
#(
   parameter int ROWS = 10
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     acc,
   input  wire req_type  req,
   output item_type      item
);

   localparam int RA_W = $clog2(ROWS);
   localparam logic [RA_W-1:0]  ROW_LAST = RA_W'(ROWS - 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

   logic [RA_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic               vis_ff, vis_in;
   logic               blink_ff, blink_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   op_type             op_ff, op_in;
   logic               counted;
   logic               rst_key;

   // decode one key beat
   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      vis_in   = vis_ff;
      blink_in = blink_ff;
      op_in    = op_ff;
      counted  = 1'b0;
      rst_key  = 1'b0;
      if (acc) begin
         blink_in = req.blink_phase;
         op_in    = OP_KEEP;
         if (req.key_valid) begin
            unique case (req.mode)
               KEY_RESET: begin
                  rst_key = 1'b1;
                  op_in   = OP_CLEAR;
                  row_in  = '0;
                  col_in  = '0;
                  vis_in  = 1'b1;
               end
               KEY_UP: begin
                  if (row_ff != '0) row_in = row_ff - 1'b1;
                  counted = 1'b1;
               end
               KEY_DOWN: begin
                  if (row_ff != ROW_LAST) row_in = row_ff + 1'b1;
                  counted = 1'b1;
               end
               KEY_LEFT: begin
                  if (col_ff != '0) col_in = col_ff - 1'b1;
                  counted = 1'b1;
               end
               KEY_RIGHT: begin
                  if (col_ff != COL_LAST) col_in = col_ff + 1'b1;
                  counted = 1'b1;
               end
               KEY_TOGGLE: begin
                  vis_in  = ~vis_ff;
                  counted = 1'b1;
               end
               KEY_SET: begin
                  op_in   = OP_SET;
                  counted = 1'b1;
               end
               KEY_CLEAR: begin
                  op_in   = OP_CLEAR;
                  counted = 1'b1;
               end
               KEY_INVERT: begin
                  op_in   = OP_INVERT;
                  counted = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // press counter, decimal wrap
   always_comb begin
      count_in = count_ff;
      if (rst_key) begin
         count_in = '0;
      end else if (counted) begin
         count_in = (count_ff == COUNT_MAX) ? '0 : count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         vis_ff   <= 1'b1;
         blink_ff <= 1'b0;
         count_ff <= '0;
         op_ff    <= OP_KEEP;
      end else begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         vis_ff   <= vis_in;
         blink_ff <= blink_in;
         count_ff <= count_in;
         op_ff    <= op_in;
      end
   end

   assign item.op      = op_ff;
   assign item.cur_row = ROW_IDX_W'(row_ff);
   assign item.cur_col = col_ff;
   assign item.visible = vis_ff;
   assign item.blink   = blink_ff;
   assign item.count   = count_ff;

endmodule

`default_nettype wire

>>> rtl/dmsp_sweep.sv
`default_nettype none

// row sweep: read each board row, apply the pending op, write back, emit
module dmsp_sweep
   import dmsp_pkg::*;
#(
   parameter int ROWS = 10
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire item_type item,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_data
);

   localparam int RA_W = $clog2(ROWS);
   localparam logic [RA_W-1:0] ROW_LAST = RA_W'(ROWS - 1);

   state_type       state_ff, state_in;
   logic [RA_W-1:0] rd_row_ff, rd_row_in;
   logic [RA_W-1:0] dat_row_ff, dat_row_in;
   logic            dat_vld_ff, dat_vld_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic            load;
   logic            rd_en;
   logic            wr_en;
   logic [RA_W-1:0] wr_addr;
   logic [COLS-1:0] wr_data;
   logic [COLS-1:0] rd_data;
   logic [COLS-1:0] col_bit;
   logic            on_cursor;
   logic [COLS-1:0] stored_new;
   logic [COLS-1:0] shown;

   dmsp_ram #(
      .WIDTH (COLS),
      .DEPTH (ROWS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_row_ff),
      .rd_data (rd_data)
   );

   // the RAM read register doubles as a holding stage while the output stalls
   assign load  = dat_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign rd_en = (state_ff == ST_RUN) && (!dat_vld_ff || load);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT:  if (rd_row_ff == ROW_LAST) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_RUN;
         ST_RUN:   if (rd_en && rd_row_ff == ROW_LAST) state_in = ST_DRAIN;
         ST_DRAIN: if (load) state_in = ST_IDLE;
         default:  state_in = ST_INIT;
      endcase
   end

   // state outputs: clearing pass writes zeros, otherwise write back on load
   always_comb begin
      req_stall = 1'b1;
      wr_en     = load;
      wr_addr   = dat_row_ff;
      wr_data   = stored_new;
      unique case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = rd_row_ff;
            wr_data = '0;
         end
         ST_IDLE:  req_stall = 1'b0;
         ST_RUN:   req_stall = 1'b1;
         ST_DRAIN: req_stall = 1'b1;
         default:  req_stall = 1'b1;
      endcase
   end

   // row pointers and the read-data flag
   always_comb begin
      rd_row_in  = rd_row_ff;
      dat_row_in = dat_row_ff;
      if (state_ff == ST_INIT || rd_en) begin
         rd_row_in = (rd_row_ff == ROW_LAST) ? '0 : rd_row_ff + 1'b1;
      end
      if (rd_en) begin
         dat_row_in = rd_row_ff;
      end
      dat_vld_in = rd_en || (dat_vld_ff && !load);
   end

   // modify the row and overlay the cursor
   always_comb begin
      col_bit   = col_mask(item.cur_col);
      on_cursor = (ROW_IDX_W'(dat_row_ff) == item.cur_row);
      case (item.op)
         OP_CLEAR:  stored_new = '0;
         OP_INVERT: stored_new = ~rd_data;
         OP_SET:    stored_new = on_cursor ? (rd_data | col_bit) : rd_data;
         default:   stored_new = rd_data;
      endcase
      shown = stored_new;
      if (item.visible && on_cursor) begin
         shown = item.blink ? (stored_new & ~col_bit) : (stored_new | col_bit);
      end
   end

   // output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      if (load) begin
         rsp_in.row_index   = ROW_IDX_W'(dat_row_ff);
         rsp_in.row_bits    = shown;
         rsp_in.press_count = item.count;
         rsp_in.last_row    = (dat_row_ff == ROW_LAST);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rd_row_ff    <= '0;
         dat_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_row_ff    <= rd_row_in;
         dat_vld_ff   <= dat_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dat_row_ff <= dat_row_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/dot_matrix_sketch_pad.sv
// Dot-matrix sketch pad: a bitmap editor for a ROWS x 7 dot display.
// Input channel req_*: one beat per key event (mode, key_valid, blink_phase).
// Result channel rsp_*: ROWS beats per input beat, top row first, each with
// the row's dots (column 0 at the MSB), the keypress count and a last_row
// flag on the final row. The cursor dot is shown on even blink phases and
// hidden on odd ones while the cursor is visible.
// The first row passes through the RAM read register and then the output
// register once the input beat is taken; the rows then follow one per
// cycle while rsp_stall stays low. Each input beat is served by a single
// read-modify-write pass over the board RAM.
// req_stall is high for the whole pass; the next beat is taken as soon as
// the last row has entered the output register, even if it is still held.
// rsp_stall holds the current row and pauses the pass without loss.
// Reset (synchronous, active high) clears the cursor, counter and stall
// state and then runs a clearing pass over the board RAM, during which
// req_stall stays high. The reset key restores the cursor and counter as reset
// does, clearing the board during its own pass.
`default_nettype none

`include "dot_matrix_sketch_pad_defines.svh"

module dot_matrix_sketch_pad
   import dmsp_pkg::*;
#(
   parameter int ROWS = 10
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam logic [ROW_IDX_W-1:0] ROW_LAST = ROW_IDX_W'(ROWS - 1);

   logic     req_acc;
   item_type item;

   assign req_acc = req_valid && !req_stall;

   dmsp_cmd #(
      .ROWS (ROWS)
   ) u_cmd (
      .clock (clock),
      .reset (reset),
      .acc   (req_acc),
      .req   (req_data),
      .item  (item)
   );

   dmsp_sweep #(
      .ROWS (ROWS)
   ) u_sweep (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .item      (item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a taken key beat starts a pass, so the input closes at once
   `DMSP_ASSERT_NEXT(a_acc_closes, clock, reset, req_acc, req_stall)
   // rows stay on the board
   `DMSP_ASSERT_SAME(a_row_range, clock, reset, rsp_valid, rsp_data.row_index <= ROW_LAST)
   // last_row marks exactly the bottom row
   `DMSP_ASSERT_SAME(a_last_row, clock, reset, rsp_valid,
      rsp_data.last_row == (rsp_data.row_index == ROW_LAST))
   // count stays decimal
   `DMSP_ASSERT_SAME(a_count_range, clock, reset, rsp_valid, rsp_data.press_count <= COUNT_MAX)

endmodule

`default_nettype wire

>>> tb/tb_dot_matrix_sketch_pad.sv
`timescale 1ns / 100ps

module tb_dot_matrix_sketch_pad;
   import dmsp_pkg::*;

   localparam int ROWS        = 10;
   localparam int CYCLE_LIMIT = 800000;
   localparam int MAX_PRINTS  = 40;

   // mode codes outside the key set
   localparam logic [MODE_W-1:0] FIRST_UNUSED = 4'(KEY_INVERT) + 4'd1;
   localparam logic [MODE_W-1:0] MODE_TOP     = '1;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   dot_matrix_sketch_pad #(
      .ROWS(ROWS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // own copy of the editor state
   logic [COLS-1:0]      board_img [ROWS];
   logic [ROW_IDX_W-1:0] cur_row;
   logic [COL_W-1:0]     cur_col;
   logic [COUNT_W-1:0]   key_count;
   logic                 cur_shown;

   rsp_type pending_rows[$];
   rsp_type want_row;
   int      errors      = 0;
   int      cycle_count = 0;
   bit      quiet       = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      if (errors <= MAX_PRINTS)
         $display("mismatch at cycle %0d: %s got %0d expected %0d",
                  cycle_count, what, got, want);
   endtask

   function automatic logic [COLS-1:0] dot_at(input logic [COL_W-1:0] col);
      return 7'b100_0000 >> col;
   endfunction

   function automatic void clear_editor();
      for (int r = 0; r < ROWS; r++)
         board_img[r] = '0;
      cur_row   = '0;
      cur_col   = '0;
      key_count = '0;
      cur_shown = 1'b1;
   endfunction

   // apply one key to the state, then queue the rows it draws
   function automatic void apply_key_and_draw(input req_type item);
      rsp_type         row;
      logic [COLS-1:0] bits;
      logic            counted;
      counted = 1'b0;
      if (item.key_valid) begin
         counted = 1'b1;
         case (item.mode)
            KEY_RESET: begin
               clear_editor();
               counted = 1'b0;
            end
            KEY_UP: begin
               if (cur_row > 0) cur_row--;
            end
            KEY_TOGGLE: cur_shown = ~cur_shown;
            KEY_LEFT: begin
               if (cur_col > 0) cur_col--;
            end
            KEY_SET: board_img[cur_row] |= dot_at(cur_col);
            KEY_RIGHT: begin
               if (cur_col < COLS - 1) cur_col++;
            end
            KEY_CLEAR: begin
               for (int r = 0; r < ROWS; r++) board_img[r] = '0;
            end
            KEY_DOWN: begin
               if (cur_row < ROWS - 1) cur_row++;
            end
            KEY_INVERT: begin
               for (int r = 0; r < ROWS; r++) board_img[r] = ~board_img[r];
            end
            default: counted = 1'b0;
         endcase
      end
      if (counted)
         key_count = (key_count == COUNT_MAX) ? '0 : key_count + 1'b1;

      for (int r = 0; r < ROWS; r++) begin
         bits = board_img[r];
         if (cur_shown && r == cur_row) begin
            if (item.blink_phase) bits &= ~dot_at(cur_col);
            else                  bits |= dot_at(cur_col);
         end
         row.row_index   = ROW_IDX_W'(r);
         row.row_bits    = bits;
         row.press_count = key_count;
         row.last_row    = (r == ROWS - 1);
         pending_rows.push_back(row);
      end
   endfunction

   // one beat on the request channel, with an occasional gap ahead of it
   task automatic send_key(input logic [MODE_W-1:0] mode, input logic valid,
                           input logic phase);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid            <= 1'b1;
      req_data.mode        <= mode;
      req_data.key_valid   <= valid;
      req_data.blink_phase <= phase;
      do @(posedge clock); while (req_stall);
      apply_key_and_draw(req_data);
   endtask

   function automatic req_type random_key();
      req_type item;
      int      pick;
      pick             = $urandom_range(0, 99);
      item.blink_phase = 1'($urandom_range(0, 1));
      item.key_valid   = 1'b1;
      if (pick < 8) begin
         item.key_valid = 1'b0;
         item.mode      = MODE_W'($urandom_range(0, int'(MODE_TOP)));
      end else if (pick < 11) begin
         item.mode = MODE_W'($urandom_range(int'(FIRST_UNUSED), int'(MODE_TOP)));
      end else if (pick < 13) begin
         item.mode = KEY_NONE;
      end else if (pick < 15) begin
         item.mode = KEY_RESET;
      end else begin
         item.mode = MODE_W'($urandom_range(int'(KEY_UP), int'(KEY_INVERT)));
      end
      return item;
   endfunction

   task automatic send_random(input int count);
      req_type item;
      for (int i = 0; i < count; i++) begin
         item = random_key();
         send_key(item.mode, item.key_valid, item.blink_phase);
      end
   endtask

   // drop the request first so the last beat is not taken twice
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
   endtask

   // edges, ignored keys, dots, toggle, invert, clear and the reset key
   task automatic test_directed();
      send_key(KEY_NONE, 1'b0, 1'b0);
      send_key(KEY_SET, 1'b0, 1'b1);
      send_key(KEY_NONE, 1'b1, 1'b0);
      send_key(MODE_TOP, 1'b1, 1'b0);
      send_key(FIRST_UNUSED, 1'b1, 1'b1);
      send_key(KEY_UP, 1'b1, 1'b0);
      send_key(KEY_LEFT, 1'b1, 1'b1);
      send_key(KEY_SET, 1'b1, 1'b0);
      repeat (7) send_key(KEY_RIGHT, 1'b1, 1'($urandom_range(0, 1)));
      send_key(KEY_SET, 1'b1, 1'b1);
      repeat (10) send_key(KEY_DOWN, 1'b1, 1'($urandom_range(0, 1)));
      send_key(KEY_SET, 1'b1, 1'b0);
      send_key(KEY_TOGGLE, 1'b1, 1'b0);
      send_key(KEY_INVERT, 1'b1, 1'b1);
      send_key(KEY_TOGGLE, 1'b1, 1'b1);
      send_key(KEY_CLEAR, 1'b1, 1'b0);
      send_key(KEY_RESET, 1'b1, 1'b1);
   endtask

   // sender holds off until the result side has caught up
   task automatic test_drained_restart();
      wait_drained();
      send_key(KEY_DOWN, 1'b1, 1'b0);
      send_key(KEY_SET, 1'b1, 1'b1);
   endtask

   task automatic test_random_edits();
      send_random(170);
   endtask

   task automatic test_steady_stream();
      quiet = 1'b1;
      send_random(30);
   endtask

   // result side stalls in random bursts
   initial begin
      int hold_left;
      int free_left;
      hold_left = 0;
      free_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (quiet) begin
            rsp_stall <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (free_left > 0) begin
            rsp_stall <= 1'b0;
            free_left--;
         end else if ($urandom_range(0, 2) == 0) begin
            hold_left = $urandom_range(1, 13) - 1;
            rsp_stall <= 1'b1;
         end else begin
            free_left = $urandom_range(1, 20) - 1;
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each row beat with the oldest expected row
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rows.size() == 0) begin
            report_mismatch("row beat with nothing expected, row_index",
                            int'(rsp_data.row_index), -1);
         end else begin
            want_row = pending_rows.pop_front();
            if (rsp_data.row_index !== want_row.row_index)
               report_mismatch("row_index", int'(rsp_data.row_index),
                               int'(want_row.row_index));
            if (rsp_data.row_bits !== want_row.row_bits)
               report_mismatch("row_bits", int'(rsp_data.row_bits),
                               int'(want_row.row_bits));
            if (rsp_data.press_count !== want_row.press_count)
               report_mismatch("press_count", int'(rsp_data.press_count),
                               int'(want_row.press_count));
            if (rsp_data.last_row !== want_row.last_row)
               report_mismatch("last_row", int'(rsp_data.last_row),
                               int'(want_row.last_row));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_dot_matrix_sketch_pad: FAIL");
         $finish;
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      clear_editor();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_drained_restart();
      test_random_edits();
      test_steady_stream();

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (ROWS + 4) @(posedge clock);
      if (pending_rows.size() != 0)
         report_mismatch("rows left outstanding", 0, pending_rows.size());
      if (errors == 0)
         $display("tb_dot_matrix_sketch_pad: PASS");
      else
         $display("tb_dot_matrix_sketch_pad: FAIL");
      $finish;
   end

endmodule
